// ===== rtl/core/giou_pkg.sv =====
// shared types, constants and helpers of the greedy iou suppression block
package giou_pkg;

  localparam int MAX_KEPT     = 64;
  localparam int COORD_W      = 16;
  localparam int THR_W        = 16;
  localparam int POS_W        = 10;
  localparam int KEPT_TOTAL_W = 7;
  localparam int KEPT_IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int COUNT_W      = $clog2(MAX_KEPT + 1);
  localparam int SPAN_W       = COORD_W;
  localparam int AREA_W       = 2 * COORD_W;
  localparam int UNI_W        = AREA_W + 1;
  localparam int PROD_W       = UNI_W + THR_W;
  localparam int S_DATA_W     = 4 * COORD_W;
  localparam int M_DATA_W     = 24;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16384);
  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [0:0]       REG_THRESHOLD = 1'b0;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SPAN_W-1:0]         span_t;
  typedef logic [AREA_W-1:0]         area_t;

  // last field in the lowest bits
  typedef struct packed {
    coord_t bottom;
    coord_t right;
    coord_t top;
    coord_t left;
  } box_t;

  typedef struct packed {
    area_t area;
    box_t  box;
  } kept_t;

  localparam int KEPT_W = $bits(kept_t);

  typedef struct packed {
    logic  valid;
    box_t  a;
    box_t  b;
    area_t area_a;
    area_t area_b;
  } pair_req_t;

  typedef struct packed {
    logic  valid;
    logic  hit;
    area_t inter;
  } pair_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_AREA_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // length of [lo, hi], zero when the interval is empty or inverted
  function automatic span_t span_of(coord_t lo, coord_t hi);
    logic signed [COORD_W:0] d;
    d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    return (hi > lo) ? d[SPAN_W-1:0] : '0;
  endfunction

  function automatic coord_t max_c(coord_t x, coord_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic coord_t min_c(coord_t x, coord_t y);
    return (x < y) ? x : y;
  endfunction

endpackage

// ===== rtl/core/giou_ram.sv =====
// generic simple dual-port ram with registered read
module giou_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/giou_pair_unit.sv =====
// pipelined pairwise overlap test: intersection, union and threshold compare
module giou_pair_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  giou_pkg::pair_req_t       req,
  input  logic [giou_pkg::THR_W-1:0] thr,
  output giou_pkg::pair_rsp_t       rsp
);
  import giou_pkg::*;

  logic              s1_valid, s2_valid, s3_valid, s4_valid;
  span_t             s1_sx, s1_sy;
  logic [UNI_W-1:0]  s1_sum, s2_sum;
  area_t             s2_inter, s3_inter, s4_inter;
  logic [UNI_W-1:0]  s3_uni;
  logic [PROD_W-1:0] s4_prod;
  span_t             sx, sy;
  logic [PROD_W-1:0] lhs;

  always_comb begin
    sx = span_of(max_c(req.a.left, req.b.left), min_c(req.a.right, req.b.right));
    sy = span_of(max_c(req.a.top, req.b.top), min_c(req.a.bottom, req.b.bottom));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    s1_sx    <= sx;
    s1_sy    <= sy;
    s1_sum   <= {1'b0, req.area_a} + {1'b0, req.area_b};
    s2_inter <= AREA_W'(s1_sx) * AREA_W'(s1_sy);
    s2_sum   <= s1_sum;
    s3_uni   <= s2_sum - {1'b0, s2_inter};
    s3_inter <= s2_inter;
    s4_prod  <= PROD_W'(thr) * PROD_W'(s3_uni);
    s4_inter <= s3_inter;
  end

  // inter * 2^16 against thr * union, exact
  assign lhs = {1'b0, s4_inter, 16'b0};

  always_comb begin
    rsp.valid = s4_valid;
    rsp.hit   = lhs > s4_prod;
    rsp.inter = s4_inter;
  end

endmodule

// ===== rtl/core/greedy_iou_suppression.sv =====
// top level of the greedy iou non-maximum suppression block
// Boxes arrive sorted by falling score, one request at a time. Each box first
// has its own area computed, then is tested against every box kept in the
// current set, one kept box per cycle, through a single pipelined pair unit
// fed from the kept-box RAM; with the set empty the scan is skipped.
// s_tready is high only between boxes, so the next request is taken in the
// cycle after the result is registered at the earliest, and a finished result
// waits in the output register while the next box is taken. The threshold
// register is at address 0 and is to be written by the user only while idle;
// the block itself does not enforce this.
module greedy_iou_suppression (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // left [15:0], top [31:16], right [47:32], bottom [63:48]
  input  logic [giou_pkg::S_DATA_W-1:0] s_tdata,
  // start_set [0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // keep [0], box_position [10:1], kept_total [17:11], store_full [18], zero [23:19]
  output logic [giou_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [giou_pkg::PADDR_W-1:0]  paddr,
  input  logic [giou_pkg::PDATA_W-1:0]  pwdata,
  output logic [giou_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import giou_pkg::*;

  state_t                 state, state_next;
  logic [THR_W-1:0]       threshold;
  box_t                   box;
  area_t                  area;
  logic [COUNT_W-1:0]     kept_count;
  logic [POS_W-1:0]       pos_counter;
  logic [POS_W-1:0]       pos;
  logic [COUNT_W-1:0]     rd_idx;
  logic                   rd_pend;
  logic [COUNT_W-1:0]     res_cnt;
  logic                   supp;

  logic                   in_fire, fin_fire, out_free, keep_now, store_now;
  logic [POS_W-1:0]       pos_now;
  pair_req_t              req;
  pair_rsp_t              rsp;
  kept_t                  rd_word, wr_word;
  logic                   ram_we;

  assign pready   = 1'b1;
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign keep_now = !supp;
  assign store_now = keep_now && (kept_count < COUNT_W'(MAX_KEPT));
  assign pos_now  = s_tuser ? '0 : pos_counter;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? PDATA_W'(threshold) : '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_AREA;
      ST_AREA:      state_next = ST_AREA_WAIT;
      ST_AREA_WAIT: begin
        if (rsp.valid) state_next = (kept_count == '0) ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN:      if (rd_idx + COUNT_W'(1) == kept_count) state_next = ST_DRAIN;
      ST_DRAIN:     if (res_cnt == kept_count) state_next = ST_FINISH;
      ST_FINISH:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    fin_fire   = 1'b0;
    req.valid  = 1'b0;
    req.a      = box;
    req.b      = rd_word.box;
    req.area_a = area;
    req.area_b = rd_word.area;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_AREA: begin
        // the intersection of a box with itself is its area
        req.valid  = 1'b1;
        req.b      = box;
        req.area_a = '0;
        req.area_b = '0;
      end
      ST_SCAN, ST_DRAIN: req.valid = rd_pend;
      ST_FINISH: fin_fire = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      kept_count  <= '0;
      pos_counter <= '0;
      rd_idx      <= '0;
      rd_pend     <= 1'b0;
      res_cnt     <= '0;
      supp        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN);
      if (in_fire) begin
        pos         <= pos_now;
        pos_counter <= (pos_now == POS_MAX) ? POS_MAX : pos_now + POS_W'(1);
        if (s_tuser) kept_count <= '0;
        rd_idx  <= '0;
        res_cnt <= '0;
        supp    <= 1'b0;
      end
      if (state == ST_SCAN) rd_idx <= rd_idx + COUNT_W'(1);
      if ((state == ST_SCAN || state == ST_DRAIN) && rsp.valid) begin
        res_cnt <= res_cnt + COUNT_W'(1);
        if (rsp.hit) supp <= 1'b1;
      end
      if (fin_fire) begin
        m_tvalid <= 1'b1;
        if (store_now) kept_count <= kept_count + COUNT_W'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (in_fire) box <= box_t'(s_tdata);
    if (state == ST_AREA_WAIT && rsp.valid) area <= rsp.inter;
    if (fin_fire) begin
      m_tdata <= {5'b0, !store_now && keep_now,
                  KEPT_TOTAL_W'(store_now ? kept_count + COUNT_W'(1) : kept_count),
                  pos, keep_now};
    end
  end

  assign ram_we        = fin_fire && store_now;
  assign wr_word.area  = area;
  assign wr_word.box   = box;

  giou_ram #(
    .WIDTH (KEPT_W),
    .DEPTH (MAX_KEPT)
  ) u_kept_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (kept_count[KEPT_IDX_W-1:0]),
    .wdata (wr_word),
    .raddr (rd_idx[KEPT_IDX_W-1:0]),
    .rdata (rd_word)
  );

  giou_pair_unit u_pair (
    .clk (clk),
    .rst (rst),
    .req (req),
    .thr (threshold),
    .rsp (rsp)
  );

endmodule

// ===== rtl/core/giou_checker.sv =====
// port-level checker for the greedy iou suppression block, bound to the top level
module giou_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [giou_pkg::M_DATA_W-1:0] m_tdata
);
  import giou_pkg::*;

  // one box at a time: ready drops right after a request is taken
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high after a request");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[17:11] <= KEPT_TOTAL_W'(MAX_KEPT))
    else $error("kept total beyond store size");

  // full store is only reported for a kept box
  a_full_needs_keep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[0])
    else $error("store full without keep");

endmodule

bind greedy_iou_suppression giou_checker u_giou_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/greedy_iou_suppression_test.sv =====
// self-checking testbench for the greedy iou suppression block
`timescale 1ns / 100ps

localparam int KEPT_DEPTH    = 64;
localparam int POS_LIMIT     = 1023;
localparam int THRESHOLD_REG = 0;
localparam int SPARE_REG     = 1;
localparam logic [15:0] THR_DEFAULT = 16'd16384;

typedef longint unsigned u64_t;

typedef struct packed {
  logic       store_full;
  logic [6:0] kept_total;
  logic [9:0] position;
  logic       keep;
} nms_verdict_t;

class nms_scoreboard;
  logic [15:0]    threshold;
  giou_pkg::box_t kept_box[KEPT_DEPTH];
  u64_t           kept_area[KEPT_DEPTH];
  int             kept_count;
  int             position;
  nms_verdict_t   verdict_q[$];
  int errors, kept_n, suppressed_n, full_n, saturated_n, sets_n, thr_writes;

  function new();
    threshold = THR_DEFAULT;
    kept_count = 0;
    position = 0;
    errors = 0;
    kept_n = 0;
    suppressed_n = 0;
    full_n = 0;
    saturated_n = 0;
    sets_n = 0;
    thr_writes = 0;
  endfunction

  function void write_reg(int index, logic [31:0] value);
    if (index == THRESHOLD_REG) begin
      threshold = value[15:0];
      thr_writes++;
    end
  endfunction

  static function u64_t side_len(giou_pkg::coord_t lo, giou_pkg::coord_t hi);
    return (hi > lo) ? u64_t'(longint'(hi) - longint'(lo)) : 0;
  endfunction

  // iou above threshold, compared as inter * 2^16 > thr * union
  function bit overlaps_too_much(giou_pkg::box_t a, u64_t area_a,
                                 giou_pkg::box_t b, u64_t area_b);
    giou_pkg::coord_t x0, y0, x1, y1;
    u64_t inter, uni;
    x0 = (a.left > b.left) ? a.left : b.left;
    y0 = (a.top > b.top) ? a.top : b.top;
    x1 = (a.right < b.right) ? a.right : b.right;
    y1 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    inter = side_len(x0, x1) * side_len(y0, y1);
    uni = area_a + area_b - inter;
    return (inter << 16) > (u64_t'(threshold) * uni);
  endfunction

  function void note_box(giou_pkg::box_t b, bit start_set);
    nms_verdict_t v;
    u64_t area;
    bit keep;
    if (start_set) begin
      kept_count = 0;
      position = 0;
      sets_n++;
    end
    v.position = 10'(position);
    if (position == POS_LIMIT) saturated_n++;
    if (position < POS_LIMIT) position++;
    area = side_len(b.left, b.right) * side_len(b.top, b.bottom);
    keep = 1'b1;
    for (int j = 0; j < kept_count; j++)
      if (overlaps_too_much(b, area, kept_box[j], kept_area[j])) keep = 1'b0;
    v.keep = keep;
    v.store_full = 1'b0;
    if (keep) begin
      kept_n++;
      if (kept_count < KEPT_DEPTH) begin
        kept_box[kept_count] = b;
        kept_area[kept_count] = area;
        kept_count++;
      end else begin
        v.store_full = 1'b1;
        full_n++;
      end
    end else begin
      suppressed_n++;
    end
    v.kept_total = 7'(kept_count);
    verdict_q = {verdict_q, v};
  endfunction

  function void report(string field, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  function void check_result(logic [23:0] data);
    nms_verdict_t want, got;
    got = data[18:0];
    if (verdict_q.size() == 0) begin
      errors++;
      $display("%0t: result with no box outstanding, expected none, actual %h", $time, data);
      return;
    end
    want = verdict_q.pop_front();
    if (got.keep !== want.keep) report("keep", 64'(want.keep), 64'(got.keep));
    if (got.position !== want.position)
      report("box_position", 64'(want.position), 64'(got.position));
    if (got.kept_total !== want.kept_total)
      report("kept_total", 64'(want.kept_total), 64'(got.kept_total));
    if (got.store_full !== want.store_full)
      report("store_full", 64'(want.store_full), 64'(got.store_full));
    if (data[23:19] !== 5'd0) report("padding", 64'd0, 64'(data[23:19]));
  endfunction
endclass

module greedy_iou_suppression_test;
  import giou_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = PADDR_W'(4 * THRESHOLD_REG);
  localparam logic [PADDR_W-1:0] SPARE_ADDR     = PADDR_W'(4 * SPARE_REG);
  localparam coord_t CORNERS[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  nms_scoreboard sb = new();

  int   burst_left = 0;
  int   set_left = 0;
  int   cx = 0;
  int   cy = 0;
  box_t last_box = '0;
  bit   long_hold_req = 1'b0;

  greedy_iou_suppression u_dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // receiver: switches between always ready, random stalls and a fixed duty cycle, with a long stall on request
  initial begin
    int hold_left, mode, mode_left, period, tick;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    period = 2;
    tick = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left == 0 && long_hold_req) begin
        hold_left = 600;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
          period = $urandom_range(2, 6);
        end
        mode_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= (tick % period == 0);
        endcase
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("greedy_iou_suppression verification failed");
    $finish;
  end

  function automatic box_t mk(int l, int t, int r, int b);
    box_t x;
    x.left = coord_t'(l);
    x.top = coord_t'(t);
    x.right = coord_t'(r);
    x.bottom = coord_t'(b);
    return x;
  endfunction

  function automatic box_t random_box();
    box_t b;
    int sel, w, h, jx, jy, col, row;
    sel = $urandom_range(0, 99);
    w = $urandom_range(8, 1500);
    h = $urandom_range(8, 1500);
    jx = int'($urandom_range(0, w / 2)) - w / 4;
    jy = int'($urandom_range(0, h / 2)) - h / 4;
    if (sel < 35) begin
      // jittered copies around the set's center, so suppression happens
      b = mk(cx - w + jx, cy - h + jy, cx + w + jx, cy + h + jy);
    end else if (sel < 60) begin
      // small boxes on a coarse grid, mostly disjoint, fill the store
      col = $urandom_range(0, 15);
      row = $urandom_range(0, 15);
      b.left = coord_t'(col * 1024 - 8192 + int'($urandom_range(0, 127)));
      b.top = coord_t'(row * 1024 - 8192 + int'($urandom_range(0, 127)));
      b.right = coord_t'(int'(b.left) + int'($urandom_range(1, 900)));
      b.bottom = coord_t'(int'(b.top) + int'($urandom_range(1, 900)));
    end else if (sel < 70) begin
      b = last_box;
    end else if (sel < 80) begin
      b = {$urandom, $urandom};
      if ($urandom_range(0, 1))
        b.right = coord_t'(int'(b.left) - int'($urandom_range(0, 300)));
      else
        b.bottom = coord_t'(int'(b.top) - int'($urandom_range(0, 300)));
    end else if (sel < 85) begin
      b = {CORNERS[$urandom_range(0, 3)], CORNERS[$urandom_range(0, 3)],
           CORNERS[$urandom_range(0, 3)], CORNERS[$urandom_range(0, 3)]};
    end else begin
      b = {$urandom, $urandom};
    end
    return b;
  endfunction

  task automatic offer_box(box_t b, bit start_set);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= start_set;
    do @(posedge clk); while (!s_tready);
    sb.note_box(b, start_set);
    last_box = b;
  endtask

  task automatic idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(int'(addr) / 4, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(int count, int min_set, int max_set);
    bit start;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      if ($urandom_range(0, 79) == 0) wait_drained();
      start = 1'b0;
      if (set_left == 0) begin
        start = 1'b1;
        set_left = $urandom_range(min_set, max_set);
        cx = int'($urandom_range(0, 56000)) - 28000;
        cy = int'($urandom_range(0, 56000)) - 28000;
      end
      set_left--;
      offer_box(random_box(), start);
    end
  endtask

  // runs at the reset threshold of one quarter
  task automatic run_directed();
    offer_box(mk(0, 0, 160, 160), 1'b1);
    offer_box(mk(0, 0, 160, 160), 1'b0);
    offer_box(mk(320, 320, 480, 480), 1'b0);
    offer_box(mk(100, 0, 50, 100), 1'b0);
    offer_box(mk(0, 100, 100, 50), 1'b0);
    offer_box(mk(-32768, -32768, 32767, 32767), 1'b0);
    offer_box(mk(-32768, -32768, 32767, 32767), 1'b0);
    // shares only an edge with the first box
    offer_box(mk(160, 0, 320, 160), 1'b0);
    offer_box(mk(32767, 32767, -32768, -32768), 1'b0);
    offer_box(mk(5, 5, 5, 5), 1'b0);
    offer_box(mk(0, 0, 160, 160), 1'b1);
    // iou exactly one quarter, not above it
    offer_box(mk(96, 0, 256, 160), 1'b0);
    offer_box(mk(80, 0, 240, 160), 1'b0);
    offer_box(mk(-32768, -32768, -32767, -32767), 1'b0);
    offer_box(mk(32767, 32767, 32767, 32767), 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    wait_drained();

    write_reg(THRESHOLD_ADDR, {16'($urandom), 16'h0000});
    write_reg(SPARE_ADDR, $urandom);
    run_phase(30, 1, 150);
    wait_drained();

    write_reg(THRESHOLD_ADDR, {16'($urandom), 16'hffff});
    long_hold_req = 1'b1;
    run_phase(30, 1, 150);
    wait_drained();

    write_reg(THRESHOLD_ADDR, $urandom);
    run_phase(30, 1, 150);
    wait_drained();

    // one long set pushes the position counter into saturation
    write_reg(THRESHOLD_ADDR, {16'($urandom), 16'h8000});
    set_left = 0;
    run_phase(1030, 1030, 1030);
    wait_drained();

    write_reg(THRESHOLD_ADDR, $urandom);
    set_left = 0;
    run_phase(30, 1, 100);
    wait_drained();
    repeat (100) @(posedge clk);

    $display("boxes checked: %0d in %0d sets across %0d threshold writes",
             sb.kept_n + sb.suppressed_n, sb.sets_n, sb.thr_writes);
    $display("kept %0d, suppressed %0d, kept with list full %0d, at saturated position %0d",
             sb.kept_n, sb.suppressed_n, sb.full_n, sb.saturated_n);
    if (sb.errors == 0) begin
      $display("greedy_iou_suppression verification clean");
    end else begin
      $display("greedy_iou_suppression verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/giou_pkg.sv
rtl/core/giou_ram.sv
rtl/core/giou_pair_unit.sv
rtl/core/greedy_iou_suppression.sv
rtl/core/giou_checker.sv
tb/greedy_iou_suppression_test.sv
